// ----- design/lwpp_pkg.sv -----
`default_nettype none

package lwpp_pkg;

  localparam int unsigned ScreenSize = 132;

  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegClipLeft      = 3'd0;
  localparam logic [RegIdxW-1:0] RegClipTop       = 3'd1;
  localparam logic [RegIdxW-1:0] RegClipRight     = 3'd2;
  localparam logic [RegIdxW-1:0] RegClipBottom    = 3'd3;
  localparam logic [RegIdxW-1:0] RegCmdColumnSet  = 3'd4;
  localparam logic [RegIdxW-1:0] RegCmdPageSet    = 3'd5;
  localparam logic [RegIdxW-1:0] RegCmdMemoryWrite = 3'd6;

  localparam logic [7:0] RstClipLeft        = 8'd0;
  localparam logic [7:0] RstClipTop         = 8'd0;
  localparam logic [7:0] RstClipRight       = 8'(ScreenSize);
  localparam logic [7:0] RstClipBottom      = 8'(ScreenSize);
  localparam logic [7:0] RstCmdColumnSet    = 8'd21;
  localparam logic [7:0] RstCmdPageSet      = 8'd117;
  localparam logic [7:0] RstCmdMemoryWrite  = 8'd92;

  localparam logic OpWindow = 1'b0;
  localparam logic OpPixel  = 1'b1;

  localparam int unsigned MaxBytes = 7;

  typedef struct packed {
    logic       is_cmd;
    logic [7:0] value;
  } out_byte_t;

endpackage

`default_nettype wire

// ----- design/lcd_window_pixel_packer.sv -----
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    operation, win_*, pixel_color
// out       output     out_valid_o / out_ready_i  is_command, byte_value, last_of_run
// apb       input      psel, penable, pwrite      paddr, pwdata, prdata
//
// An item is registered, then worked out combinationally into a result buffer of up to
// seven bytes, which drains at one byte per cycle while out_ready_i is high. A window
// that is not clipped away gives seven bytes on the output side and a pixel pair three.
// Items that cause no bytes pass without waiting for the buffer to drain. The next item
// is taken while the last byte of the previous one is being delivered. Reset clears all
// control state and loads the register reset values.

module lcd_window_pixel_packer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic signed [9:0] win_x_i,
  input  wire logic signed [9:0] win_y_i,
  input  wire logic [8:0]        win_width_i,
  input  wire logic [8:0]        win_height_i,
  input  wire logic [11:0]       pixel_color_i,

  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_command_o,
  output logic [7:0]             byte_value_o,
  output logic                   last_of_run_o,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [7:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [7:0] cmd_column_set_q, cmd_page_set_q, cmd_memory_write_q;

  logic [lwpp_pkg::RegIdxW-1:0] reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q        <= lwpp_pkg::RstClipLeft;
      clip_top_q         <= lwpp_pkg::RstClipTop;
      clip_right_q       <= lwpp_pkg::RstClipRight;
      clip_bottom_q      <= lwpp_pkg::RstClipBottom;
      cmd_column_set_q   <= lwpp_pkg::RstCmdColumnSet;
      cmd_page_set_q     <= lwpp_pkg::RstCmdPageSet;
      cmd_memory_write_q <= lwpp_pkg::RstCmdMemoryWrite;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lwpp_pkg::RegClipLeft:       clip_left_q        <= pwdata[7:0];
        lwpp_pkg::RegClipTop:        clip_top_q         <= pwdata[7:0];
        lwpp_pkg::RegClipRight:      clip_right_q       <= pwdata[7:0];
        lwpp_pkg::RegClipBottom:     clip_bottom_q      <= pwdata[7:0];
        lwpp_pkg::RegCmdColumnSet:   cmd_column_set_q   <= pwdata[7:0];
        lwpp_pkg::RegCmdPageSet:     cmd_page_set_q     <= pwdata[7:0];
        lwpp_pkg::RegCmdMemoryWrite: cmd_memory_write_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lwpp_pkg::RegClipLeft:       prdata = {24'd0, clip_left_q};
      lwpp_pkg::RegClipTop:        prdata = {24'd0, clip_top_q};
      lwpp_pkg::RegClipRight:      prdata = {24'd0, clip_right_q};
      lwpp_pkg::RegClipBottom:     prdata = {24'd0, clip_bottom_q};
      lwpp_pkg::RegCmdColumnSet:   prdata = {24'd0, cmd_column_set_q};
      lwpp_pkg::RegCmdPageSet:     prdata = {24'd0, cmd_page_set_q};
      lwpp_pkg::RegCmdMemoryWrite: prdata = {24'd0, cmd_memory_write_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // Input register.
  logic                   s1_valid_q;
  logic                   s1_op_q;
  logic signed [9:0]      s1_x_q, s1_y_q;
  logic [8:0]             s1_w_q, s1_h_q;
  logic [11:0]            s1_color_q;
  logic                   s1_adv;

  // Block state.
  logic [15:0] pixels_left_q, pixels_left_d;
  logic [11:0] held_color_q, held_color_d;
  logic        held_valid_q, held_valid_d;

  // Result buffer.
  logic                buf_valid_q;
  logic [2:0]          buf_cnt_q;
  logic [2:0]          buf_idx_q;
  lwpp_pkg::out_byte_t buf_q [lwpp_pkg::MaxBytes];
  lwpp_pkg::out_byte_t res_d [lwpp_pkg::MaxBytes];
  logic [2:0]          res_cnt;
  logic                out_take, out_fin, buf_free;

  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q    <= operation_i;
      s1_x_q     <= win_x_i;
      s1_y_q     <= win_y_i;
      s1_w_q     <= win_width_i;
      s1_h_q     <= win_height_i;
      s1_color_q <= pixel_color_i;
    end
  end

  // Window clipping, in 12-bit signed arithmetic.
  logic signed [11:0] l_s, t_s, r_s, b_s;
  logic signed [11:0] x0, y0, w0, h0, x1, y1, w1, h1, w2, h2;
  logic               win_empty;
  logic [7:0]         w8, h8, col_last, row_last;
  logic [15:0]        area;

  always_comb begin
    l_s = $signed({4'd0, clip_left_q});
    t_s = $signed({4'd0, clip_top_q});
    r_s = $signed({4'd0, clip_right_q});
    b_s = $signed({4'd0, clip_bottom_q});
    x0  = 12'(s1_x_q);
    y0  = 12'(s1_y_q);
    w0  = $signed({3'd0, s1_w_q});
    h0  = $signed({3'd0, s1_h_q});
    if (x0 < l_s) begin
      w1 = w0 - (l_s - x0);
      x1 = l_s;
    end else begin
      w1 = w0;
      x1 = x0;
    end
    if (y0 < t_s) begin
      h1 = h0 - (t_s - y0);
      y1 = t_s;
    end else begin
      h1 = h0;
      y1 = y0;
    end
    win_empty = (w1 <= 12'sd0) || (h1 <= 12'sd0) || (x1 >= r_s) || (y1 >= b_s);
    w2 = (x1 + w1 > r_s) ? (r_s - x1) : w1;
    h2 = (y1 + h1 > b_s) ? (b_s - y1) : h1;
    w8 = w2[7:0];
    h8 = h2[7:0];
    col_last = x1[7:0] + w8 - 8'd1;
    row_last = y1[7:0] + h8 - 8'd1;
    area = {8'd0, w8} * {8'd0, h8};
  end

  // Result bytes and next state.
  always_comb begin
    pixels_left_d = pixels_left_q;
    held_color_d  = held_color_q;
    held_valid_d  = held_valid_q;
    res_cnt       = 3'd0;
    for (int i = 0; i < lwpp_pkg::MaxBytes; i++) begin
      res_d[i] = '0;
    end
    if (s1_op_q == lwpp_pkg::OpWindow) begin
      held_valid_d = 1'b0;
      held_color_d = 12'd0;
      if (win_empty) begin
        pixels_left_d = 16'd0;
      end else begin
        pixels_left_d = area;
        res_cnt  = 3'd7;
        res_d[0] = '{is_cmd: 1'b1, value: cmd_column_set_q};
        res_d[1] = '{is_cmd: 1'b0, value: x1[7:0]};
        res_d[2] = '{is_cmd: 1'b0, value: col_last};
        res_d[3] = '{is_cmd: 1'b1, value: cmd_page_set_q};
        res_d[4] = '{is_cmd: 1'b0, value: y1[7:0]};
        res_d[5] = '{is_cmd: 1'b0, value: row_last};
        res_d[6] = '{is_cmd: 1'b1, value: cmd_memory_write_q};
      end
    end else if (pixels_left_q != 16'd0) begin
      pixels_left_d = pixels_left_q - 16'd1;
      res_d[2] = '{is_cmd: 1'b0, value: s1_color_q[7:0]};
      if (held_valid_q) begin
        held_valid_d = 1'b0;
        held_color_d = 12'd0;
        res_cnt  = 3'd3;
        res_d[0] = '{is_cmd: 1'b0, value: held_color_q[11:4]};
        res_d[1] = '{is_cmd: 1'b0, value: {held_color_q[3:0], s1_color_q[11:8]}};
      end else if (pixels_left_q == 16'd1) begin
        res_cnt  = 3'd3;
        res_d[0] = '{is_cmd: 1'b0, value: 8'd0};
        res_d[1] = '{is_cmd: 1'b0, value: {4'd0, s1_color_q[11:8]}};
      end else begin
        held_valid_d = 1'b1;
        held_color_d = s1_color_q;
      end
    end
  end

  assign out_valid_o   = buf_valid_q;
  assign out_take      = out_valid_o & out_ready_i;
  assign last_of_run_o = (buf_idx_q == buf_cnt_q - 3'd1);
  assign out_fin       = out_take & last_of_run_o;
  assign buf_free      = !buf_valid_q || out_fin;
  assign s1_adv        = s1_valid_q && ((res_cnt == 3'd0) || buf_free);

  assign is_command_o = buf_q[buf_idx_q].is_cmd;
  assign byte_value_o = buf_q[buf_idx_q].value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_left_q <= 16'd0;
      held_color_q  <= 12'd0;
      held_valid_q  <= 1'b0;
      buf_valid_q   <= 1'b0;
      buf_cnt_q     <= 3'd0;
      buf_idx_q     <= 3'd0;
    end else begin
      if (s1_adv) begin
        pixels_left_q <= pixels_left_d;
        held_color_q  <= held_color_d;
        held_valid_q  <= held_valid_d;
      end
      if (s1_adv && (res_cnt != 3'd0)) begin
        buf_valid_q <= 1'b1;
        buf_cnt_q   <= res_cnt;
        buf_idx_q   <= 3'd0;
      end else if (out_fin) begin
        buf_valid_q <= 1'b0;
      end else if (out_take) begin
        buf_idx_q <= buf_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (res_cnt != 3'd0)) begin
      for (int i = 0; i < lwpp_pkg::MaxBytes; i++) begin
        buf_q[i] <= res_d[i];
      end
    end
  end

endmodule

`default_nettype wire
